FILE: design/bbc_pkg.sv
// Shared types and constants for the block buffer cache tag manager.
// No dependencies; imported by bbc_group_sel and block_buffer_cache_lru.
package bbc_pkg;

   localparam int MODE_W   = 2;
   localparam int DEVICE_W = 8;
   localparam int BLOCK_W  = 32;
   localparam int WAY_W    = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 8;

   localparam logic [MODE_W-1:0] MODE_GET     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PIN     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNPIN   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_BUFFER = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
   localparam logic [COUNT_W-1:0] COUNT_ONE = 8'd1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_GROUP,
      ST_SCAN,
      ST_GET_WB,
      ST_OP_RD,
      ST_OP_WB,
      ST_LRU,
      ST_LRU_END
   } state_type;

   // Reference count increment that holds at the maximum.
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] count);
      sat_inc = (count == COUNT_MAX) ? count : count + COUNT_ONE;
   endfunction

endpackage

FILE: design/bbc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/bbc_group_sel.sv
// Group selection: block number modulo GROUPS, from the low bits for a power of two,
// otherwise by exact reciprocal multiply and a quotient register. Depends on bbc_pkg.
module bbc_group_sel #(
   parameter int GROUPS = 64
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   input  logic [bbc_pkg::BLOCK_W-1:0]                block_number,
   output logic                                       done,
   output logic [(GROUPS > 1 ? $clog2(GROUPS) : 1)-1:0] group
);

   import bbc_pkg::*;

   localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   generate
      if ((GROUPS & (GROUPS - 1)) == 0) begin : g_pow2
         logic          done_ff;
         logic [GW-1:0] group_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               group_ff <= (GROUPS == 1) ? '0 : block_number[GW-1:0];
            end
         end

         assign done  = done_ff;
         assign group = group_ff;
      end else begin : g_recip
         // The quotient is exact as (x * RECIP) >> (BLOCK_W + GW) for every 32-bit x.
         // The remainder is below 2**GW, so only the low GW bits of x - q * GROUPS count.
         localparam int RW = BLOCK_W + 1;
         localparam int PW = 2 * BLOCK_W + 1;
         localparam logic [RW-1:0] RECIP =
            RW'(((64'd1 << (BLOCK_W + GW)) + 64'(GROUPS) - 64'd1) / 64'(GROUPS));

         logic          stage_ff;
         logic          done_ff;
         logic [PW-1:0] product;
         logic [GW-1:0] quot_lo_ff;
         logic [GW-1:0] blk_lo_ff;
         logic [GW-1:0] rem_ff;
         logic [GW-1:0] rem_in;

         always_comb begin
            product = PW'(block_number) * PW'(RECIP);
            rem_in  = blk_lo_ff - quot_lo_ff * GW'(GROUPS);
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               stage_ff <= 1'b0;
               done_ff  <= 1'b0;
            end else begin
               stage_ff <= start;
               done_ff  <= stage_ff;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               quot_lo_ff <= product[BLOCK_W + GW +: GW];
               blk_lo_ff  <= block_number[GW-1:0];
            end
            if (stage_ff) begin
               rem_ff <= rem_in;
            end
         end

         assign done  = done_ff;
         assign group = rem_ff;
      end
   endgenerate

endmodule

FILE: design/block_buffer_cache_lru.sv
// Top level of the block buffer cache tag manager with per-group LRU replacement.
// Depends on bbc_pkg, bbc_ram and bbc_group_sel.
//
//   Channel   Direction  Handshake           Payload
//   req_*     in         req_valid/req_stall  mode, device, block_number, way
//   rsp_*     out        rsp_valid/rsp_stall  status, way_out, hit, needs_read
//
// After reset the block writes the reset tags and ranks into all GROUPS * 2**WW slots
// of the slot RAM (256 at the defaults), and takes no request meanwhile.
// A sweep visits every way of the group through the single read port of the slot RAM,
// one way per cycle. A get sweeps the group; a release that brings a count to zero reads
// the addressed slot and then sweeps the group; any other request reads only that slot.
// req_stall holds off each new request until the current one is back in ST_IDLE.
// A result waits in the output register under rsp_stall; a finished request that finds
// the register still full holds its final state until the register drains.
module block_buffer_cache_lru #(
   parameter int GROUPS = 64,
   parameter int WAYS   = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bbc_pkg::MODE_W-1:0]    req_mode,
   input  logic [bbc_pkg::DEVICE_W-1:0]  req_device,
   input  logic [bbc_pkg::BLOCK_W-1:0]   req_block_number,
   input  logic [bbc_pkg::WAY_W-1:0]     req_way,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bbc_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bbc_pkg::WAY_W-1:0]     rsp_way_out,
   output logic                          rsp_hit,
   output logic                          rsp_needs_read
);

   import bbc_pkg::*;

   // Address of a slot is {group, way}; a group occupies 2**WW consecutive slots.
   localparam int GW        = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int WW        = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WI        = $clog2(WAYS + 1);
   localparam int AW        = GW + WW;
   localparam int RAM_DEPTH = 1 << AW;
   localparam int CLEAR_N   = GROUPS * (1 << WW);

   // Slot word layout, low to high: rank, count, valid, block tag, device tag.
   localparam int CNT_LSB = WW;
   localparam int VLD_BIT = CNT_LSB + COUNT_W;
   localparam int BLK_LSB = VLD_BIT + 1;
   localparam int DEV_LSB = BLK_LSB + BLOCK_W;
   localparam int WORD_W  = DEV_LSB + DEVICE_W;

   state_type state_ff, state_in;

   // Captured request.
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [DEVICE_W-1:0] dev_ff, dev_in;
   logic [BLOCK_W-1:0]  blk_ff, blk_in;
   logic [WW-1:0]       way_ff, way_in;
   logic                way_ok_ff, way_ok_in;
   logic [GW-1:0]       group_ff, group_in;

   // Way sweep: read issue index and the way whose data arrives this cycle.
   logic [WI-1:0] rd_idx_ff, rd_idx_in;
   logic          pend_ff, pend_in;
   logic [WW-1:0] cmp_way_ff, cmp_way_in;
   logic          issue;

   // Best matching way (highest rank) and best free way (lowest rank).
   logic               hit_found_ff, hit_found_in;
   logic [WW-1:0]      hit_way_ff, hit_way_in;
   logic [WW-1:0]      hit_rank_ff, hit_rank_in;
   logic [COUNT_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic               hit_valid_ff, hit_valid_in;
   logic               free_found_ff, free_found_in;
   logic [WW-1:0]      free_way_ff, free_way_in;
   logic [WW-1:0]      free_rank_ff, free_rank_in;
   logic [WW-1:0]      old_rank_ff, old_rank_in;

   logic [AW-1:0] clr_idx_ff, clr_idx_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [WAY_W-1:0]    rsp_way_out_ff, rsp_way_out_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic                rsp_needs_read_ff, rsp_needs_read_in;
   logic                can_load;
   logic [WW-1:0]       res_way;
   logic [31:0]         res_way_wide;
   logic [31:0]         req_way_wide;

   // Slot RAM ports.
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [WORD_W-1:0] ram_rdata;

   logic [DEVICE_W-1:0] rd_dev;
   logic [BLOCK_W-1:0]  rd_blk;
   logic                rd_valid;
   logic [COUNT_W-1:0]  rd_cnt;
   logic [WW-1:0]       rd_rank;
   logic [WW-1:0]       lru_rank;
   logic [COUNT_W-1:0]  lru_cnt;

   logic          grp_start;
   logic          grp_done;
   logic [GW-1:0] grp_group;

   bbc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (RAM_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   bbc_group_sel #(
      .GROUPS (GROUPS)
   ) u_group_sel (
      .clock        (clock),
      .reset        (reset),
      .start        (grp_start),
      .block_number (req_block_number),
      .done         (grp_done),
      .group        (grp_group)
   );

   assign rd_dev   = ram_rdata[DEV_LSB +: DEVICE_W];
   assign rd_blk   = ram_rdata[BLK_LSB +: BLOCK_W];
   assign rd_valid = ram_rdata[VLD_BIT];
   assign rd_cnt   = ram_rdata[CNT_LSB +: COUNT_W];
   assign rd_rank  = ram_rdata[WW-1:0];

   assign req_way_wide = 32'(req_way);
   assign res_way_wide = 32'(res_way);

   assign issue     = (rd_idx_ff < WI'(WAYS));
   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in          = state_ff;
      mode_in           = mode_ff;
      dev_in            = dev_ff;
      blk_in            = blk_ff;
      way_in            = way_ff;
      way_ok_in         = way_ok_ff;
      group_in          = group_ff;
      rd_idx_in         = rd_idx_ff;
      pend_in           = pend_ff;
      cmp_way_in        = cmp_way_ff;
      hit_found_in      = hit_found_ff;
      hit_way_in        = hit_way_ff;
      hit_rank_in       = hit_rank_ff;
      hit_cnt_in        = hit_cnt_ff;
      hit_valid_in      = hit_valid_ff;
      free_found_in     = free_found_ff;
      free_way_in       = free_way_ff;
      free_rank_in      = free_rank_ff;
      old_rank_in       = old_rank_ff;
      clr_idx_in        = clr_idx_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_status_in     = rsp_status_ff;
      rsp_way_out_in    = rsp_way_out_ff;
      rsp_hit_in        = rsp_hit_ff;
      rsp_needs_read_in = rsp_needs_read_ff;
      res_way           = '0;
      ram_we            = 1'b0;
      ram_waddr         = '0;
      ram_wdata         = '0;
      ram_re            = 1'b0;
      ram_raddr         = {group_ff, rd_idx_ff[WW-1:0]};
      grp_start         = 1'b0;
      lru_rank          = rd_rank;
      lru_cnt           = rd_cnt;

      case (state_ff)
         ST_CLEAR: begin
            // Reset contents: zero tags and counts, rank equal to the way index.
            ram_we     = 1'b1;
            ram_waddr  = clr_idx_ff;
            ram_wdata  = {{(WORD_W - WW){1'b0}}, clr_idx_ff[WW-1:0]};
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == AW'(CLEAR_N - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               grp_start     = 1'b1;
               mode_in       = req_mode;
               dev_in        = req_device;
               blk_in        = req_block_number;
               way_in        = req_way_wide[WW-1:0];
               way_ok_in     = (req_way_wide < 32'(WAYS));
               rd_idx_in     = '0;
               pend_in       = 1'b0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               state_in      = ST_GROUP;
            end
         end

         ST_GROUP: begin
            if (grp_done) begin
               group_in = grp_group;
               state_in = (mode_ff == MODE_GET) ? ST_SCAN : ST_OP_RD;
            end
         end

         ST_SCAN: begin
            // One way read per cycle; the compare runs on the previous read.
            ram_re     = issue;
            pend_in    = issue;
            cmp_way_in = rd_idx_ff[WW-1:0];
            if (issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (pend_ff) begin
               if (rd_dev == dev_ff && rd_blk == blk_ff &&
                   (!hit_found_ff || rd_rank > hit_rank_ff)) begin
                  hit_found_in = 1'b1;
                  hit_way_in   = cmp_way_ff;
                  hit_rank_in  = rd_rank;
                  hit_cnt_in   = rd_cnt;
                  hit_valid_in = rd_valid;
               end
               if (rd_cnt == '0 && (!free_found_ff || rd_rank < free_rank_ff)) begin
                  free_found_in = 1'b1;
                  free_way_in   = cmp_way_ff;
                  free_rank_in  = rd_rank;
               end
            end
            if (!issue && !pend_ff) begin
               state_in = ST_GET_WB;
            end
         end

         ST_GET_WB: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (hit_found_ff) begin
                  // Hit: raise the count and mark the data valid.
                  ram_we            = 1'b1;
                  ram_waddr         = {group_ff, hit_way_ff};
                  ram_wdata         = {dev_ff, blk_ff, 1'b1, sat_inc(hit_cnt_ff), hit_rank_ff};
                  res_way           = hit_way_ff;
                  rsp_status_in     = STATUS_OK;
                  rsp_hit_in        = 1'b1;
                  rsp_needs_read_in = !hit_valid_ff;
               end else if (free_found_ff) begin
                  // Miss: retag the least recent unreferenced way.
                  ram_we            = 1'b1;
                  ram_waddr         = {group_ff, free_way_ff};
                  ram_wdata         = {dev_ff, blk_ff, 1'b1, COUNT_ONE, free_rank_ff};
                  res_way           = free_way_ff;
                  rsp_status_in     = STATUS_OK;
                  rsp_hit_in        = 1'b0;
                  rsp_needs_read_in = 1'b1;
               end else begin
                  rsp_status_in     = STATUS_NO_BUFFER;
                  rsp_hit_in        = 1'b0;
                  rsp_needs_read_in = 1'b0;
               end
               rsp_way_out_in = res_way_wide[WAY_W-1:0];
            end
         end

         ST_OP_RD: begin
            ram_re    = 1'b1;
            ram_raddr = {group_ff, way_ff};
            state_in  = ST_OP_WB;
         end

         ST_OP_WB: begin
            // Read data holds here while the output register is full. The reply
            // fields load only when the output register can take them.
            ram_waddr         = {group_ff, way_ff};
            ram_wdata         = ram_rdata;
            if (can_load) begin
               rsp_way_out_in    = '0;
               rsp_hit_in        = 1'b0;
               rsp_needs_read_in = 1'b0;
               rsp_status_in     = STATUS_OK;
            end
            if (!way_ok_ff) begin
               if (can_load) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (mode_ff == MODE_PIN) begin
               if (can_load) begin
                  ram_we                            = 1'b1;
                  ram_wdata[CNT_LSB +: COUNT_W]     = sat_inc(rd_cnt);
                  rsp_valid_in                      = 1'b1;
                  state_in                          = ST_IDLE;
               end
            end else if (rd_cnt == '0) begin
               if (can_load) begin
                  rsp_status_in = STATUS_UNDERFLOW;
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (mode_ff == MODE_RELEASE && rd_cnt == COUNT_ONE) begin
               // Count reaches zero on release: sweep the group to move this way to
               // the most recent rank.
               old_rank_in = rd_rank;
               rd_idx_in   = '0;
               pend_in     = 1'b0;
               state_in    = ST_LRU;
            end else if (can_load) begin
               ram_we                        = 1'b1;
               ram_wdata[CNT_LSB +: COUNT_W] = rd_cnt - COUNT_ONE;
               rsp_valid_in                  = 1'b1;
               state_in                      = ST_IDLE;
            end
         end

         ST_LRU: begin
            ram_re     = issue;
            pend_in    = issue;
            cmp_way_in = rd_idx_ff[WW-1:0];
            if (issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (pend_ff) begin
               if (cmp_way_ff == way_ff) begin
                  lru_rank = WW'(WAYS - 1);
                  lru_cnt  = '0;
               end else if (rd_rank > old_rank_ff) begin
                  lru_rank = rd_rank - 1'b1;
               end
               ram_we    = 1'b1;
               ram_waddr = {group_ff, cmp_way_ff};
               ram_wdata = {rd_dev, rd_blk, rd_valid, lru_cnt, lru_rank};
            end
            if (!issue && !pend_ff) begin
               state_in = ST_LRU_END;
            end
         end

         ST_LRU_END: begin
            if (can_load) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = STATUS_OK;
               rsp_way_out_in    = '0;
               rsp_hit_in        = 1'b0;
               rsp_needs_read_in = 1'b0;
               state_in          = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         rd_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and scan bookkeeping; every use is qualified by control state.
   always_ff @(posedge clock) begin
      mode_ff           <= mode_in;
      dev_ff            <= dev_in;
      blk_ff            <= blk_in;
      way_ff            <= way_in;
      way_ok_ff         <= way_ok_in;
      group_ff          <= group_in;
      cmp_way_ff        <= cmp_way_in;
      hit_found_ff      <= hit_found_in;
      hit_way_ff        <= hit_way_in;
      hit_rank_ff       <= hit_rank_in;
      hit_cnt_ff        <= hit_cnt_in;
      hit_valid_ff      <= hit_valid_in;
      free_found_ff     <= free_found_in;
      free_way_ff       <= free_way_in;
      free_rank_ff      <= free_rank_in;
      old_rank_ff       <= old_rank_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_way_out_ff    <= rsp_way_out_in;
      rsp_hit_ff        <= rsp_hit_in;
      rsp_needs_read_ff <= rsp_needs_read_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_way_out    = rsp_way_out_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_needs_read = rsp_needs_read_ff;

endmodule
